FILE: design/bccc_pkg.sv
// ----------------------------------------------------------------------------
// bccc_pkg
// Shared constants, types and modular helpers for the bounded coin change
// way counter.
// ----------------------------------------------------------------------------
package bccc_pkg;

  localparam int unsigned MAX_SUM = 1024;
  localparam int unsigned ADDR_W  = $clog2(MAX_SUM);
  localparam int unsigned VAL_W   = 10;
  localparam int unsigned MULT_W  = VAL_W + 1;
  localparam int unsigned SPAN_W  = MULT_W + VAL_W;
  localparam int unsigned WAY_W   = 27;

  localparam logic [WAY_W-1:0] WAY_MOD = WAY_W'(100000007);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY,
    ST_COPY_END,
    ST_SL_RD,
    ST_SL_ADD,
    ST_SL_WR,
    ST_MU_RD,
    ST_MU_LD,
    ST_MU_IT,
    ST_MU_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic copy_rd;
    logic copy_end;
    logic sl_add;
    logic sl_wr;
    logic mu_ld;
    logic mu_it;
    logic mu_wr;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic value_zero;
    logic bits_zero;
    logic last;
    logic out_free;
  } status_t;

  function automatic logic [WAY_W-1:0] add_mod(input logic [WAY_W-1:0] a,
                                               input logic [WAY_W-1:0] b);
    logic [WAY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, WAY_MOD}) begin
      s = s - {1'b0, WAY_MOD};
    end
    return s[WAY_W-1:0];
  endfunction

  function automatic logic [WAY_W-1:0] sub_mod(input logic [WAY_W-1:0] a,
                                               input logic [WAY_W-1:0] b);
    logic [WAY_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, WAY_MOD} - {1'b0, b};
    end
    return s[WAY_W-1:0];
  endfunction

endpackage

FILE: design/bounded_coin_change_count_top.sv
// ----------------------------------------------------------------------------
// bounded_coin_change_count_top
// Counts the ways to reach target_sum from bounded coin kinds, mod 100000007.
// ----------------------------------------------------------------------------
// One coin kind is taken at a time; in_stall_o stays high while it is folded.
// A fold first copies the way table into the scratch row and then rewrites
// each entry with a window sum in three steps, read, add and subtract-write.
// A coin of value zero instead scales each entry by limit + 1 in a
// bit-serial modular multiplier. After a coin marked last the count at
// target_sum is loaded into the output register and the table restarts
// from one way at sum zero with no extra pass. The next coin can be
// accepted while the result waits to be taken. The user must write target_sum
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bounded_coin_change_count_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bccc_pkg::VAL_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bccc_pkg::VAL_W-1:0] coin_value_i,
  input  logic [bccc_pkg::VAL_W-1:0] coin_limit_i,
  input  logic                       last_coin_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bccc_pkg::WAY_W-1:0] way_count_o
);
  import bccc_pkg::*;

  cmd_t    cmd;
  status_t status;

  bccc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bccc_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .coin_value_i (coin_value_i),
    .coin_limit_i (coin_limit_i),
    .last_coin_i  (last_coin_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .way_count_o  (way_count_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

FILE: design/bccc_ctrl.sv
// ----------------------------------------------------------------------------
// bccc_ctrl
// Sequencer for one coin fold: copy pass, window or multiply pass, result.
// ----------------------------------------------------------------------------
module bccc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bccc_pkg::status_t status_i,
  output bccc_pkg::cmd_t    cmd_o
);
  import bccc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_COPY;
      ST_COPY:     if (status_i.idx_end) state_d = ST_COPY_END;
      ST_COPY_END: state_d = status_i.value_zero ? ST_MU_RD : ST_SL_RD;
      ST_SL_RD:    state_d = ST_SL_ADD;
      ST_SL_ADD:   state_d = ST_SL_WR;
      ST_SL_WR:    state_d = status_i.idx_end ? ST_DONE : ST_SL_RD;
      ST_MU_RD:    state_d = ST_MU_LD;
      ST_MU_LD:    state_d = ST_MU_IT;
      ST_MU_IT:    if (status_i.bits_zero) state_d = ST_MU_WR;
      ST_MU_WR:    state_d = status_i.idx_end ? ST_DONE : ST_MU_RD;
      ST_DONE:     if (!status_i.last || status_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.load   = in_valid_i;
        cmd_o.idx_clr = 1'b1;
      end
      ST_COPY: begin
        cmd_o.copy_rd = 1'b1;
        cmd_o.idx_clr = status_i.idx_end;
        cmd_o.idx_inc = !status_i.idx_end;
      end
      ST_COPY_END: cmd_o.copy_end = 1'b1;
      ST_SL_ADD:   cmd_o.sl_add = 1'b1;
      ST_SL_WR: begin
        cmd_o.sl_wr   = 1'b1;
        cmd_o.idx_clr = status_i.idx_end;
        cmd_o.idx_inc = !status_i.idx_end;
      end
      ST_MU_LD: cmd_o.mu_ld = 1'b1;
      ST_MU_IT: cmd_o.mu_it = !status_i.bits_zero;
      ST_MU_WR: begin
        cmd_o.mu_wr   = 1'b1;
        cmd_o.idx_clr = status_i.idx_end;
        cmd_o.idx_inc = !status_i.idx_end;
      end
      ST_DONE: cmd_o.out_ld = status_i.last && status_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: design/bccc_dpath.sv
// ----------------------------------------------------------------------------
// bccc_dpath
// Way table, scratch row, window adder, serial modular multiplier and
// output register.
// ----------------------------------------------------------------------------
module bccc_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bccc_pkg::VAL_W-1:0]   cfg_wdata_i,
  input  logic [bccc_pkg::VAL_W-1:0]   coin_value_i,
  input  logic [bccc_pkg::VAL_W-1:0]   coin_limit_i,
  input  logic                         last_coin_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bccc_pkg::WAY_W-1:0]   way_count_o,
  input  bccc_pkg::cmd_t               cmd_i,
  output bccc_pkg::status_t            status_o
);
  import bccc_pkg::*;

  logic [WAY_W-1:0]  ways_mem    [MAX_SUM];
  logic [WAY_W-1:0]  scratch_mem [MAX_SUM];

  logic [VAL_W-1:0]  target_q;
  logic [VAL_W-1:0]  value_q;
  logic [MULT_W-1:0] mult_q;
  logic [MULT_W-1:0] mult_d;
  logic [SPAN_W-1:0] span_q;
  logic [SPAN_W-1:0] span_d;
  logic              last_q;
  logic              cleared_q;
  logic [ADDR_W-1:0] idx_q;
  logic              cp_v_q;
  logic [ADDR_W-1:0] cp_idx_q;
  logic [WAY_W-1:0]  ways_rdata_q;
  logic [WAY_W-1:0]  sc0_rdata_q;
  logic [WAY_W-1:0]  sc1_rdata_q;
  logic [WAY_W-1:0]  stage_q;
  logic [WAY_W-1:0]  x_q;
  logic [WAY_W-1:0]  acc_q;
  logic [MULT_W-1:0] bits_q;
  logic [WAY_W-1:0]  res_q;
  logic              out_valid_q;
  logic [WAY_W-1:0]  way_count_q;

  logic              ge_value;
  logic              ge_span;
  logic [ADDR_W-1:0] ways_raddr;
  logic [ADDR_W-1:0] drop_addr;
  logic [WAY_W-1:0]  scratch_wdata;
  logic [WAY_W-1:0]  sl_val;
  logic              ways_we;
  logic [WAY_W-1:0]  ways_wdata;
  logic              hit_target;

  assign mult_d = MULT_W'({1'b0, coin_limit_i}) + MULT_W'(1);
  assign span_d = SPAN_W'(mult_d) * SPAN_W'(coin_value_i);

  assign ge_value   = 32'(idx_q) >= 32'(value_q);
  assign ge_span    = 32'(idx_q) >= 32'(span_q);
  assign ways_raddr = cmd_i.copy_rd ? idx_q : ADDR_W'(32'(idx_q) - 32'(value_q));
  assign drop_addr  = ADDR_W'(32'(idx_q) - 32'(span_q));
  assign hit_target = 32'(idx_q) == 32'(target_q);

  assign scratch_wdata = cleared_q ? ((cp_idx_q == '0) ? WAY_W'(1) : '0) : ways_rdata_q;
  assign sl_val        = ge_span ? sub_mod(stage_q, sc1_rdata_q) : stage_q;
  assign ways_we       = cmd_i.sl_wr || cmd_i.mu_wr;
  assign ways_wdata    = cmd_i.mu_wr ? acc_q : sl_val;

  always_ff @(posedge clk_i) begin
    if (ways_we) begin
      ways_mem[idx_q] <= ways_wdata;
    end
    ways_rdata_q <= ways_mem[ways_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cp_v_q) begin
      scratch_mem[cp_idx_q] <= scratch_wdata;
    end
    sc0_rdata_q <= scratch_mem[idx_q];
    sc1_rdata_q <= scratch_mem[drop_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      cleared_q   <= 1'b1;
      idx_q       <= '0;
      cp_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + ADDR_W'(1);
      end
      cp_v_q <= cmd_i.copy_rd;
      if (cmd_i.copy_end) begin
        cleared_q <= 1'b0;
      end else if (cmd_i.out_ld) begin
        cleared_q <= 1'b1;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cp_idx_q <= idx_q;
    if (cmd_i.load) begin
      value_q <= coin_value_i;
      mult_q  <= mult_d;
      span_q  <= span_d;
      last_q  <= last_coin_i;
      res_q   <= '0;
    end else if (ways_we && hit_target) begin
      res_q <= ways_wdata;
    end
    if (cmd_i.sl_add) begin
      stage_q <= ge_value ? add_mod(sc0_rdata_q, ways_rdata_q) : sc0_rdata_q;
    end
    if (cmd_i.mu_ld) begin
      x_q    <= sc0_rdata_q;
      acc_q  <= '0;
      bits_q <= mult_q;
    end else if (cmd_i.mu_it) begin
      if (bits_q[0]) begin
        acc_q <= add_mod(acc_q, x_q);
      end
      x_q    <= add_mod(x_q, x_q);
      bits_q <= bits_q >> 1;
    end
    if (cmd_i.out_ld) begin
      way_count_q <= res_q;
    end
  end

  assign status_o.idx_end    = idx_q == ADDR_W'(MAX_SUM - 1);
  assign status_o.value_zero = value_q == '0;
  assign status_o.bits_zero  = bits_q == '0;
  assign status_o.last       = last_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign way_count_o = way_count_q;

endmodule

FILE: design/bccc_checker.sv
// ----------------------------------------------------------------------------
// bccc_checker
// Port-level checks of the way counter, bound to the top level.
// ----------------------------------------------------------------------------
module bccc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [bccc_pkg::WAY_W-1:0] way_count_o
);
  import bccc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(way_count_o))
    else $error("result dropped or changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> way_count_o < WAY_MOD)
    else $error("way count not reduced");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted without a fold");

  a_result_from_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a fold in progress");

endmodule

bind bounded_coin_change_count_top bccc_checker u_bccc_checker (.*);

FILE: test/way_count_checker.sv
// ----------------------------------------------------------------------------
// way_count_checker
// Watches the configuration port and both item channels of the bounded coin
// change counter. It keeps its own table of way counts by sum, folds in every
// accepted coin, queues the count at the target sum for each coin marked last
// and compares every accepted result with the oldest queued count.
// ----------------------------------------------------------------------------
module way_count_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bccc_pkg::VAL_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [bccc_pkg::VAL_W-1:0] coin_value_i,
  input  logic [bccc_pkg::VAL_W-1:0] coin_limit_i,
  input  logic                       last_coin_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [bccc_pkg::WAY_W-1:0] way_count_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import bccc_pkg::*;

  localparam longint unsigned MODULUS = 64'(WAY_MOD);

  logic [WAY_W-1:0] sum_ways [MAX_SUM];
  logic [VAL_W-1:0] report_sum;
  logic [WAY_W-1:0] expected_counts [$];
  logic [WAY_W-1:0] wanted;
  int               mismatches = 0;

  function automatic void reset_ways();
    for (int s = 0; s < MAX_SUM; s++) begin
      sum_ways[s] = '0;
    end
    sum_ways[0] = WAY_W'(1);
  endfunction

  function automatic void apply_coin(input logic [VAL_W-1:0] value,
                                     input logic [VAL_W-1:0] limit);
    logic [WAY_W-1:0] prior [MAX_SUM];
    longint unsigned  factor;
    longint unsigned  span;
    longint unsigned  acc;
    longint unsigned  drop;
    prior  = sum_ways;
    factor = 64'(limit) + 64'd1;
    span   = factor * 64'(value);
    if (value == '0) begin
      for (int s = 0; s < MAX_SUM; s++) begin
        acc = (64'(prior[s]) * factor) % MODULUS;
        sum_ways[s] = acc[WAY_W-1:0];
      end
    end else begin
      for (int s = 0; s < MAX_SUM; s++) begin
        acc = 64'(prior[s]);
        if (s >= int'(value)) begin
          acc = acc + 64'(sum_ways[s - int'(value)]);
          if (acc >= MODULUS) begin
            acc = acc - MODULUS;
          end
        end
        if (64'(s) >= span) begin
          drop = 64'(prior[s - int'(span)]);
          acc  = (acc >= drop) ? acc - drop : acc + MODULUS - drop;
        end
        sum_ways[s] = acc[WAY_W-1:0];
      end
    end
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", what);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_ways();
      report_sum = '0;
      expected_counts.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_counts.size() == 0) begin
          note_mismatch($sformatf("unexpected way_count: got %0d", way_count_i));
        end else begin
          wanted = expected_counts.pop_front();
          if (wanted !== way_count_i) begin
            note_mismatch($sformatf("way_count mismatch: expected %0d, got %0d",
                                    wanted, way_count_i));
          end
        end
      end
      if (cfg_we_i) begin
        report_sum = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        apply_coin(coin_value_i, coin_limit_i);
        if (last_coin_i) begin
          if (int'(report_sum) < MAX_SUM) begin
            expected_counts.push_back(sum_ways[report_sum]);
          end else begin
            expected_counts.push_back('0);
          end
          reset_ways();
        end
      end
      pending_o <= expected_counts.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

FILE: test/bounded_coin_change_count_top_test.sv
// ----------------------------------------------------------------------------
// bounded_coin_change_count_top_test
// Drives coin kinds and target sums into the bounded coin change counter:
// a directed set of edge cases first, then random problems over several
// target settings with random sender gaps and receiver stalls, the last
// setting without idling. The checker beside the block predicts each count.
// ----------------------------------------------------------------------------
module bounded_coin_change_count_top_test;
  import bccc_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 4 * MAX_SUM + 16;
  localparam int unsigned WATCHDOG_LIMIT = 100000;
  localparam int unsigned DIRECTED_COINS = 23;
  localparam int unsigned COINS_PER_SET  = 54;
  localparam int unsigned TARGET_SETS    = 5;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_we_i     = 1'b0;
  logic [VAL_W-1:0] cfg_wdata_i  = '0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic [VAL_W-1:0] coin_value_i = '0;
  logic [VAL_W-1:0] coin_limit_i = '0;
  logic             last_coin_i  = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic [WAY_W-1:0] way_count_o;

  int          fail_count;
  int          pending;
  bit          quiet       = 1'b0;
  int unsigned coins_sent  = 0;
  int unsigned stall_run   = 0;
  int unsigned idle_cycles = 0;

  bounded_coin_change_count_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .coin_value_i (coin_value_i),
    .coin_limit_i (coin_limit_i),
    .last_coin_i  (last_coin_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .way_count_o  (way_count_o)
  );

  way_count_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .coin_value_i (coin_value_i),
    .coin_limit_i (coin_limit_i),
    .last_coin_i  (last_coin_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .way_count_i  (way_count_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_run == 0 && !quiet && $urandom_range(0, 3) == 0) begin
        stall_run = $urandom_range(1, 18);
      end
      if (stall_run != 0) begin
        out_stall_i = 1'b1;
        stall_run--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_coin(input logic [VAL_W-1:0] value, input logic [VAL_W-1:0] limit,
                           input logic is_last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    coin_value_i = value;
    coin_limit_i = limit;
    last_coin_i  = is_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    coins_sent++;
  endtask

  task automatic hold_for_results();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_target(input logic [VAL_W-1:0] target);
    hold_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = target;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) return '0;
    if (pick < 60) return VAL_W'($urandom_range(1, 24));
    if (pick < 85) return VAL_W'($urandom_range(1, 200));
    return VAL_W'($urandom_range(1, 1023));
  endfunction

  function automatic logic [VAL_W-1:0] pick_limit();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return VAL_W'($urandom_range(0, 2));
    if (pick < 70) return VAL_W'($urandom_range(0, 40));
    return VAL_W'($urandom_range(0, 1023));
  endfunction

  task automatic send_problem(input int unsigned coins);
    for (int unsigned i = 0; i < coins; i++) begin
      send_coin(pick_value(), pick_limit(), i == coins - 1);
    end
  endtask

  initial begin
    logic [VAL_W-1:0] target;
    int unsigned      goal;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_coin(10'd1023, 10'd1023, 1'b1);
    send_coin(10'd0, 10'd0, 1'b1);

    set_target(10'd1023);
    send_coin(10'd1, 10'd1023, 1'b1);
    send_coin(10'd1, 10'd1022, 1'b1);
    send_coin(10'd0, 10'd1023, 1'b0);
    send_coin(10'd1, 10'd1023, 1'b1);
    send_coin(10'd3, 10'd5, 1'b0);
    send_coin(10'd7, 10'd2, 1'b0);
    send_coin(10'd1023, 10'd1, 1'b0);
    send_coin(10'd512, 10'd1, 1'b0);
    send_coin(10'd511, 10'd1, 1'b1);
    send_coin(10'd2, 10'd0, 1'b0);
    send_coin(10'd1, 10'd1023, 1'b1);

    set_target(10'd512);
    send_coin(10'd1, 10'd1, 1'b0);
    send_coin(10'd2, 10'd3, 1'b0);
    send_coin(10'd5, 10'd1023, 1'b0);
    send_coin(10'd0, 10'd1, 1'b0);
    send_coin(10'd1, 10'd1023, 1'b1);
    send_coin(10'd1, 10'd1023, 1'b0);
    send_coin(10'd1, 10'd1023, 1'b0);
    send_coin(10'd1, 10'd1023, 1'b0);
    send_coin(10'd1, 10'd1023, 1'b0);
    send_coin(10'd1, 10'd1023, 1'b1);

    for (int unsigned set = 0; set < TARGET_SETS; set++) begin
      case (set)
        1:       target = '1;
        2:       target = '0;
        3:       target = VAL_W'($urandom_range(1, 64));
        default: target = VAL_W'($urandom_range(0, 1023));
      endcase
      set_target(target);
      if (set == TARGET_SETS - 1) begin
        quiet = 1'b1;
      end
      goal = DIRECTED_COINS + (set + 1) * COINS_PER_SET;
      while (coins_sent < goal) begin
        if ($urandom_range(0, 9) == 0) begin
          send_problem($urandom_range(8, 12));
        end else begin
          send_problem($urandom_range(1, 6));
        end
        if (!quiet && $urandom_range(0, 9) == 0) begin
          hold_for_results();
        end
      end
    end

    hold_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
